@@ design/ffmt_pkg.sv @@
// Shared types and constants of the first-fit max-tree allocator.
// Holds the fixed field widths, function codes, config reset value and the shared arithmetic unit's beat structs.
// No dependencies.
package ffmt_pkg;

	localparam int WORD_W    = 32;
	localparam int SLOT_W    = 10;
	localparam int CFG_W     = 11;
	localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

	localparam logic FUNC_LOAD    = 1'b0;
	localparam logic FUNC_REQUEST = 1'b1;

	// operands into the shared compare/subtract unit
	typedef struct packed {
		logic [WORD_W-1:0] a;
		logic [WORD_W-1:0] b;
	} alu_in_t;

	// results out of the shared compare/subtract unit
	typedef struct packed {
		logic [WORD_W-1:0] diff;
		logic              ge;
		logic [WORD_W-1:0] max;
	} alu_out_t;

endpackage

@@ design/first_fit_max_tree_allocator.sv @@
// First-fit max-tree allocator, top level with sequencer; L tree levels (10 for 1024 slots).
// Busy after acceptance: a request walks the root, L levels down, the leaf and L levels up; a load
// walks down and up; a fit beyond the count or a root miss ends early. A zero-count request strobes
// done without going busy, an ignored load does nothing; other requests strobe done as busy falls.
// One item at a time; the receiver cannot stall results. Reset zeroes all 4*SLOTS node rows, busy high.
module first_fit_max_tree_allocator #(
	parameter int SLOTS = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  logic                              func,
	input  logic [ffmt_pkg::SLOT_W-1:0]       slot_index,
	input  logic [ffmt_pkg::WORD_W-1:0]       amount,
	output logic                              done,
	output logic                              found,
	output logic [ffmt_pkg::SLOT_W-1:0]       chosen_slot,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ffmt_pkg::CFG_W-1:0]        slots_in_use
);

	localparam int DEPTH = 4 * SLOTS;
	localparam int NW    = $clog2(DEPTH);
	localparam int IW    = ($clog2(SLOTS) + 1 > ffmt_pkg::CFG_W + 1) ?
	                       $clog2(SLOTS) + 1 : ffmt_pkg::CFG_W + 1;
	localparam logic [NW-1:0] ROOT     = NW'(1);
	localparam logic [NW-1:0] LAST_ROW = NW'(DEPTH - 1);
	localparam logic [IW-1:0] SLOTS_I  = IW'(SLOTS);

	typedef enum logic [5:0] {
		S_CLEAR = 6'b000001,
		S_IDLE  = 6'b000010,
		S_ROOT  = 6'b000100,
		S_DOWN  = 6'b001000,
		S_LEAF  = 6'b010000,
		S_UP    = 6'b100000
	} state_t;

	state_t                         state_q;
	logic [NW-1:0]                  clr_q;
	logic [NW-1:0]                  node_q;
	logic [IW-1:0]                  lo_q;
	logic [IW-1:0]                  hi_q;
	logic                           func_q;
	logic [ffmt_pkg::SLOT_W-1:0]    slot_q;
	logic [ffmt_pkg::WORD_W-1:0]    amt_q;
	logic [ffmt_pkg::WORD_W-1:0]    val_q;
	logic [ffmt_pkg::CFG_W-1:0]     slots_q;
	logic                           done_q;
	logic                           found_q;
	logic [ffmt_pkg::SLOT_W-1:0]    chosen_q;

	logic [IW:0]                    mid_sum;
	logic [IW-1:0]                  mid;
	logic [IW-1:0]                  count;
	logic [IW-1:0]                  new_lo;
	logic [IW-1:0]                  new_hi;
	logic                           go_left;
	logic                           at_leaf;
	logic [NW-1:0]                  child_base;
	logic [NW-1:0]                  new_node;
	logic [NW-1:0]                  parent;
	logic [NW-1:0]                  rd_addr;
	logic [ffmt_pkg::WORD_W-1:0]    rd_data;
	logic                           wr_en;
	logic [NW-1:0]                  wr_addr;
	logic [ffmt_pkg::WORD_W-1:0]    wr_data;
	ffmt_pkg::alu_in_t              alu_in;
	ffmt_pkg::alu_out_t             alu_out;

	ffmt_alu u_alu (
		.op  (alu_in),
		.res (alu_out)
	);

	ffmt_node_ram #(
		.DEPTH (DEPTH),
		.AW    (NW)
	) u_ram (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_addr),
		.wdata (wr_data),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	assign busy        = (state_q != S_IDLE);
	assign cfg_ready   = 1'b1;
	assign done        = done_q;
	assign found       = found_q;
	assign chosen_slot = chosen_q;

	// effective slot count saturates at SLOTS
	assign count = (IW'(slots_q) > SLOTS_I) ? SLOTS_I : IW'(slots_q);

	// split point and child of the current node
	always_comb begin
		mid_sum    = {1'b0, lo_q} + {1'b0, hi_q};
		mid        = mid_sum[IW:1];
		child_base = {node_q[NW-2:0], 1'b0};
		parent     = {1'b0, node_q[NW-1:1]};
	end

	// steer the shared unit
	always_comb begin
		alu_in.a = rd_data;
		alu_in.b = amt_q;
		case (state_q)
			S_DOWN: begin
				if (func_q == ffmt_pkg::FUNC_LOAD) begin
					alu_in.a = 32'(mid);
					alu_in.b = 32'(slot_q);
				end
			end
			S_UP: begin
				alu_in.a = val_q;
				alu_in.b = rd_data;
			end
			default: begin
			end
		endcase
	end

	// next position on the way down
	always_comb begin
		go_left  = alu_out.ge;
		new_node = child_base | {{(NW-1){1'b0}}, ~go_left};
		new_lo   = go_left ? lo_q : mid + IW'(1);
		new_hi   = go_left ? mid : hi_q;
		at_leaf  = !(new_lo < new_hi);
	end

	// memory addresses for each step
	always_comb begin
		rd_addr = ROOT;
		wr_en   = 1'b0;
		wr_addr = clr_q;
		wr_data = '0;
		case (state_q)
			S_CLEAR: begin
				wr_en = 1'b1;
			end
			S_ROOT: begin
				rd_addr = child_base;
			end
			S_DOWN: begin
				if (!at_leaf) begin
					rd_addr = {new_node[NW-2:0], 1'b0};
				end else if (func_q == ffmt_pkg::FUNC_LOAD) begin
					rd_addr = new_node ^ ROOT;
					wr_en   = 1'b1;
					wr_addr = new_node;
					wr_data = amt_q;
				end else begin
					rd_addr = new_node;
				end
			end
			S_LEAF: begin
				rd_addr = node_q ^ ROOT;
				wr_en   = 1'b1;
				wr_addr = node_q;
				wr_data = alu_out.diff;
			end
			S_UP: begin
				rd_addr = parent ^ ROOT;
				wr_en   = 1'b1;
				wr_addr = parent;
				wr_data = alu_out.max;
			end
			default: begin
			end
		endcase
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slots_q <= ffmt_pkg::CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			slots_q <= slots_in_use;
		end
	end

	// sequencer control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + NW'(1);
					if (clr_q == LAST_ROW) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						if (func == ffmt_pkg::FUNC_LOAD) begin
							if (IW'(slot_index) < count) begin
								state_q <= S_DOWN;
							end
						end else if (count == '0) begin
							done_q <= 1'b1;
						end else begin
							state_q <= S_ROOT;
						end
					end
				end
				S_ROOT: begin
					if (!alu_out.ge) begin
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else begin
						state_q <= S_DOWN;
					end
				end
				S_DOWN: begin
					if (at_leaf) begin
						if (func_q == ffmt_pkg::FUNC_LOAD) begin
							state_q <= S_UP;
						end else if (new_lo >= count) begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_LEAF;
						end
					end
				end
				S_LEAF: begin
					state_q <= S_UP;
				end
				S_UP: begin
					if (parent == ROOT) begin
						done_q  <= (func_q == ffmt_pkg::FUNC_REQUEST);
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath registers: position, operands, result beat
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				func_q   <= func;
				slot_q   <= slot_index;
				amt_q    <= amount;
				node_q   <= ROOT;
				lo_q     <= '0;
				hi_q     <= SLOTS_I - IW'(1);
				found_q  <= 1'b0;
				chosen_q <= '0;
			end
			S_DOWN: begin
				node_q <= new_node;
				lo_q   <= new_lo;
				hi_q   <= new_hi;
				val_q  <= amt_q;
			end
			S_LEAF: begin
				val_q <= alu_out.diff;
			end
			S_UP: begin
				val_q  <= alu_out.max;
				node_q <= parent;
				if (parent == ROOT) begin
					found_q  <= 1'b1;
					chosen_q <= lo_q[ffmt_pkg::SLOT_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end

endmodule

@@ design/ffmt_alu.sv @@
// Shared compare/subtract unit of the allocator.
// One 32-bit subtractor gives a - b, a >= b and max(a, b). Uses ffmt_pkg.
module ffmt_alu (
	input  ffmt_pkg::alu_in_t  op,
	output ffmt_pkg::alu_out_t res
);

	logic [ffmt_pkg::WORD_W:0] sub;

	// borrow out of the subtract means a < b
	always_comb begin
		sub      = {1'b0, op.a} - {1'b0, op.b};
		res.diff = sub[ffmt_pkg::WORD_W-1:0];
		res.ge   = ~sub[ffmt_pkg::WORD_W];
		res.max  = res.ge ? op.a : op.b;
	end

endmodule

@@ design/ffmt_node_ram.sv @@
// Node store of the max-tree: one write port, one read port, registered read.
// Uses ffmt_pkg for the word width.
module ffmt_node_ram #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  logic                         clk,
	input  logic                         we,
	input  logic [AW-1:0]                waddr,
	input  logic [ffmt_pkg::WORD_W-1:0]  wdata,
	input  logic [AW-1:0]                raddr,
	output logic [ffmt_pkg::WORD_W-1:0]  rdata
);

	logic [ffmt_pkg::WORD_W-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data in the cycle after the address
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

@@ tb/sv/first_fit_max_tree_allocator_tb.sv @@
// Testbench for the first-fit max-tree allocator: directed and random load/request traffic.
// Predicts every request beat against its own slot-capacity store and checks each done strobe.
// Depends on ffmt_pkg and first_fit_max_tree_allocator.
module first_fit_max_tree_allocator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS          = 1024;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES  = 30;
	localparam int LOAD_SETTLE    = 24;

	typedef struct packed {
		logic                        found;
		logic [ffmt_pkg::SLOT_W-1:0] chosen;
	} alloc_result_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        start;
	logic                        busy;
	logic                        func;
	logic [ffmt_pkg::SLOT_W-1:0] slot_index;
	logic [ffmt_pkg::WORD_W-1:0] amount;
	logic                        done;
	logic                        found;
	logic [ffmt_pkg::SLOT_W-1:0] chosen_slot;
	logic                        cfg_valid;
	logic                        cfg_ready;
	logic [ffmt_pkg::CFG_W-1:0]  slots_in_use;

	// predicted block state
	logic [ffmt_pkg::WORD_W-1:0] slot_cap [SLOTS];
	logic [ffmt_pkg::CFG_W-1:0]  slot_count;
	alloc_result_t               expected_allocs [$];
	alloc_result_t               head_alloc;
	int                          mismatch_count = 0;
	int                          idle_cycles = 0;
	int                          max_gap = 0;

	first_fit_max_tree_allocator #(
		.SLOTS(SLOTS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.func(func),
		.slot_index(slot_index),
		.amount(amount),
		.done(done),
		.found(found),
		.chosen_slot(chosen_slot),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.slots_in_use(slots_in_use)
	);

	always #10 clk = ~clk;

	function automatic int usable_slots();
		return (int'(slot_count) > SLOTS) ? SLOTS : int'(slot_count);
	endfunction

	// Apply one accepted beat to the predicted store; a request queues its outcome.
	function automatic void predict_allocation(input logic op,
			input logic [ffmt_pkg::SLOT_W-1:0] slot, input logic [ffmt_pkg::WORD_W-1:0] amt);
		alloc_result_t res;
		int            usable;
		int            pick;
		usable = usable_slots();
		res = '0;
		pick = -1;
		if (op == ffmt_pkg::FUNC_LOAD) begin
			if (int'(slot) < usable)
				slot_cap[slot] = amt;
		end else begin
			// leftmost fit over the whole tree, usable or not
			if (usable > 0) begin
				for (int i = 0; i < SLOTS && pick < 0; i++)
					if (slot_cap[i] >= amt)
						pick = i;
			end
			if (pick >= 0 && pick < usable) begin
				slot_cap[pick] = slot_cap[pick] - amt;
				res.found = 1'b1;
				res.chosen = pick[ffmt_pkg::SLOT_W-1:0];
			end
			expected_allocs = {expected_allocs, res};
		end
	endfunction

	// Check each done strobe against the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_allocs.size() == 0) begin
				$error("unexpected result: found=%0d chosen_slot=%0d", found, chosen_slot);
				mismatch_count++;
			end else begin
				head_alloc = expected_allocs.pop_front();
				if (found !== head_alloc.found) begin
					$error("found: expected %0d, got %0d", head_alloc.found, found);
					mismatch_count++;
				end
				if (chosen_slot !== head_alloc.chosen) begin
					$error("chosen_slot: expected %0d, got %0d", head_alloc.chosen, chosen_slot);
					mismatch_count++;
				end
			end
		end
	end

	// End the run when no beat of any kind moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Send one item after a random gap; hold start high until a clock edge finds busy low.
	task automatic issue_item(input logic op, input logic [ffmt_pkg::SLOT_W-1:0] slot,
			input logic [ffmt_pkg::WORD_W-1:0] amt);
		int gap;
		gap = (max_gap > 0) ? $urandom_range(0, max_gap) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		func <= op;
		slot_index <= slot;
		amount <= amt;
		do @(posedge clk); while (busy);
		predict_allocation(op, slot, amt);
	endtask

	task automatic wait_allocs_drained();
		start <= 1'b0;
		while (expected_allocs.size() != 0) @(posedge clk);
	endtask

	// Write the slot count only once the block has gone quiet.
	task automatic write_slot_count(input logic [ffmt_pkg::CFG_W-1:0] val);
		wait_allocs_drained();
		repeat (LOAD_SETTLE) @(posedge clk);
		while (busy) @(posedge clk);
		cfg_valid <= 1'b1;
		slots_in_use <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		slot_count = val;
	endtask

	function automatic logic [ffmt_pkg::WORD_W-1:0] random_capacity();
		case ($urandom_range(0, 3))
			0: return $urandom();
			1: return $urandom_range(0, 63);
			default: return $urandom_range(0, 5000);
		endcase
	endfunction

	// Mostly sizes that fit somewhere, with zero, exact fits and wide values mixed in.
	function automatic logic [ffmt_pkg::WORD_W-1:0] random_request(input int usable);
		case ($urandom_range(0, 9))
			0: return '0;
			1: return $urandom();
			2, 3: return slot_cap[$urandom_range(0, (usable > 0) ? usable - 1 : SLOTS - 1)];
			default: return $urandom_range(1, 300);
		endcase
	endfunction

	task automatic test_empty_store();
		max_gap = 0;
		issue_item(ffmt_pkg::FUNC_REQUEST, '0, '0);
		issue_item(ffmt_pkg::FUNC_REQUEST, '1, 32'd1);
	endtask

	task automatic test_field_extremes();
		max_gap = 2;
		issue_item(ffmt_pkg::FUNC_LOAD, 10'd1023, 32'hFFFF_FFFF);
		issue_item(ffmt_pkg::FUNC_LOAD, 10'd0, 32'd5);
		issue_item(ffmt_pkg::FUNC_LOAD, 10'd512, 32'h8000_0000);
		issue_item(ffmt_pkg::FUNC_LOAD, 10'd511, 32'h7FFF_FFFF);
		issue_item(ffmt_pkg::FUNC_REQUEST, 10'h155, 32'hFFFF_FFFF);
		issue_item(ffmt_pkg::FUNC_REQUEST, 10'h2AA, 32'd5);
		issue_item(ffmt_pkg::FUNC_REQUEST, '0, 32'h7FFF_FFFF);
		issue_item(ffmt_pkg::FUNC_REQUEST, '1, 32'hAAAA_AAAA);
		issue_item(ffmt_pkg::FUNC_REQUEST, '0, '0);
	endtask

	task automatic test_slot_count_limits();
		// lowered count: old capacity above it must not be handed out
		write_slot_count(11'd16);
		issue_item(ffmt_pkg::FUNC_LOAD, 10'd16, 32'd7);
		issue_item(ffmt_pkg::FUNC_LOAD, 10'd15, 32'd100);
		issue_item(ffmt_pkg::FUNC_REQUEST, '0, 32'h8000_0000);
		issue_item(ffmt_pkg::FUNC_REQUEST, '0, 32'd100);
		// zero count: nothing loads, nothing is found
		write_slot_count(11'd0);
		issue_item(ffmt_pkg::FUNC_LOAD, 10'd0, 32'd9);
		issue_item(ffmt_pkg::FUNC_REQUEST, '0, '0);
		// count above the slot total saturates
		write_slot_count(11'd2047);
		issue_item(ffmt_pkg::FUNC_LOAD, 10'd1023, 32'd3);
		issue_item(ffmt_pkg::FUNC_REQUEST, '0, 32'h8000_0000);
		write_slot_count(11'd1);
		issue_item(ffmt_pkg::FUNC_REQUEST, '0, '0);
	endtask

	// One setting of the slot count with mixed traffic and one full drain.
	task automatic run_traffic_phase(input logic [ffmt_pkg::CFG_W-1:0] cnt, input int items);
		int                          counted;
		int                          tries;
		int                          usable;
		int                          r;
		int                          pause_at;
		logic                        op;
		logic [ffmt_pkg::SLOT_W-1:0] slot;
		logic [ffmt_pkg::WORD_W-1:0] amt;
		write_slot_count(cnt);
		usable = usable_slots();
		pause_at = $urandom_range(1, items - 1);
		counted = 0;
		tries = 0;
		while (counted < items) begin
			if (tries % 40 == 0)
				max_gap = ($urandom_range(0, 3) == 0) ? 0 : 6;
			if (tries == pause_at)
				wait_allocs_drained();
			r = $urandom_range(0, 99);
			slot = 10'($urandom_range(0, SLOTS - 1));
			if (r < 45) begin
				op = ffmt_pkg::FUNC_LOAD;
				if (r >= 4 && usable > 0)
					slot = 10'($urandom_range(0, usable - 1));
				amt = random_capacity();
			end else begin
				op = ffmt_pkg::FUNC_REQUEST;
				amt = random_request(usable);
			end
			issue_item(op, slot, amt);
			tries++;
			if (op == ffmt_pkg::FUNC_REQUEST || int'(slot) < usable)
				counted++;
		end
	endtask

	task automatic test_random_traffic();
		run_traffic_phase(11'd1024, 400);
		run_traffic_phase(11'd1, 150);
		run_traffic_phase(11'd2047, 300);
		run_traffic_phase(11'd0, 40);
		run_traffic_phase(11'($urandom_range(2, 1023)), 350);
		run_traffic_phase(11'd2, 150);
		run_traffic_phase(11'd1024, 350);
		run_traffic_phase(11'($urandom_range(0, 2047)), 300);
	endtask

	initial begin
		start <= 1'b0;
		func <= ffmt_pkg::FUNC_LOAD;
		slot_index <= '0;
		amount <= '0;
		cfg_valid <= 1'b0;
		slots_in_use <= ffmt_pkg::CFG_RESET;
		arst_n <= 1'b0;
		foreach (slot_cap[i])
			slot_cap[i] = '0;
		slot_count = ffmt_pkg::CFG_RESET;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		test_empty_store();
		test_field_extremes();
		test_slot_count_limits();
		test_random_traffic();

		// drain, then give the last load time to settle
		wait_allocs_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_allocs.size() != 0) begin
			$error("%0d expected results never arrived", expected_allocs.size());
			mismatch_count++;
		end
		if (mismatch_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
